@@ rtl/core/small_prime_divisibility_check_defines.svh @@
// Assertion macros used by the port-level checker of the divisibility checker.
// No dependencies; each macro expects clk and rst_n in the enclosing scope.
`ifndef SMALL_PRIME_DIVISIBILITY_CHECK_DEFINES_SVH
`define SMALL_PRIME_DIVISIBILITY_CHECK_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SPDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define SPDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/spdc_pkg.sv @@
// Package for the small prime divisibility checker: prime table, widths,
// register codes and modular helper functions. No dependencies.
package spdc_pkg;

    localparam int NUM_PRIMES     = 22;
    localparam int NUM_LOW_PRIMES = 8;
    localparam int RES_W          = 7;
    localparam int DIGIT_W        = 32;
    localparam int DIGIT_BITS     = 32;
    localparam int NUM_BYTES      = DIGIT_W / 8;
    localparam int COUNT_W        = 8;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 8'd32;

    typedef logic [RES_W-1:0]           res_t;
    typedef res_t [7:0]                 weights_t;
    typedef res_t [NUM_PRIMES-1:0]      res_vec_t;

    // Register index (byte address bit 2)
    typedef enum logic {
        REG_EXT_THRESHOLD = 1'b0
    } reg_idx_t;

    // Primes in ascending order, entry 0 is 7
    localparam res_vec_t PRIMES = {
        7'd97, 7'd89, 7'd83, 7'd79, 7'd73, 7'd71, 7'd67, 7'd61, 7'd59, 7'd53, 7'd47,
        7'd43, 7'd41, 7'd37, 7'd31, 7'd29, 7'd23, 7'd19, 7'd17, 7'd13, 7'd11, 7'd7
    };

    // 2^e mod p by repeated doubling
    function automatic res_t pow2_mod(input int unsigned e, input res_t p);
        logic [RES_W:0] m;
        m = (RES_W+1)'(1);
        for (int unsigned i = 0; i < e; i++) begin
            m = {m[RES_W-1:0], 1'b0};
            if (m >= {1'b0, p}) begin
                m = m - {1'b0, p};
            end
        end
        return m[RES_W-1:0];
    endfunction

    // Bit weights 2^(base+b) mod p for one byte lane
    function automatic weights_t make_weights(input int unsigned base, input res_t p);
        weights_t w;
        for (int unsigned b = 0; b < 8; b++) begin
            w[b] = pow2_mod(base + b, p);
        end
        return w;
    endfunction

    // (a + b) mod p for a, b < p
    function automatic res_t mod_add(input res_t a, input res_t b, input res_t p);
        logic [RES_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[RES_W-1:0];
    endfunction

    // Weighted byte reduced mod p: three levels of modular adds
    function automatic res_t byte_mod(input logic [7:0] v, input weights_t w, input res_t p);
        res_t l1 [4];
        res_t l2 [2];
        for (int i = 0; i < 4; i++) begin
            l1[i] = mod_add(v[2*i] ? w[2*i] : '0, v[2*i+1] ? w[2*i+1] : '0, p);
        end
        for (int i = 0; i < 2; i++) begin
            l2[i] = mod_add(l1[2*i], l1[2*i+1], p);
        end
        return mod_add(l2[0], l2[1], p);
    endfunction

endpackage

@@ rtl/core/small_prime_divisibility_check.sv @@
// Small prime divisibility checker, top level; depends on spdc_pkg.
// A last digit goes through the stage-1 register and then sets the result register.
// Throughput: one digit per cycle unless stalled; the 22 prime residues update together.
// Digit input stalls only while a last digit waits behind an untaken result.
// Reset (rst_n low, asynchronous): residues and digit count clear, threshold is 32.
module small_prime_divisibility_check
    import spdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // digit channel
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [DIGIT_W-1:0]  digit,
    input  logic                last,
    // result channel
    output logic                result_valid,
    input  logic                result_ready,
    output logic                divisible
);

    logic [COUNT_W-1:0] threshold_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_last_reg;
    logic               s1_go;
    logic               result_valid_reg;
    logic               result_valid_next;
    logic               divisible_reg;
    logic               divisible_next;
    logic               low_hit;
    logic               high_hit;
    logic [NUM_PRIMES-1:0] hit;
    res_t               part_reg  [NUM_PRIMES][NUM_BYTES];
    res_t               part_next [NUM_PRIMES][NUM_BYTES];
    res_t               res_reg   [NUM_PRIMES];
    res_t               res_next  [NUM_PRIMES];
    res_t               res_upd   [NUM_PRIMES];
    logic               cfg_write;
    reg_idx_t           cfg_idx;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write && cfg_idx == REG_EXT_THRESHOLD)
        begin
            threshold_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_EXT_THRESHOLD: prdata[COUNT_W-1:0] = threshold_reg;
            default:           prdata = '0;
        endcase
    end

    // Handshake: a stage-1 digit moves on unless it is a last digit blocked by the result
    assign s1_go        = s1_valid_reg && (!s1_last_reg || !result_valid_reg || result_ready);
    assign item_ready   = !s1_valid_reg || s1_go;
    assign result_valid = result_valid_reg;
    assign divisible    = divisible_reg;

    // Per-prime datapath
    for (genvar k = 0; k < NUM_PRIMES; k++)
    begin : g_prime
        localparam res_t     P  = PRIMES[k];
        localparam weights_t WR = make_weights(DIGIT_BITS, P);
        res_t dm;
        res_t rr;

        // Stage 1: each byte of the digit reduced mod p
        for (genvar j = 0; j < NUM_BYTES; j++)
        begin : g_byte
            localparam weights_t WB = make_weights(8 * j, P);
            assign part_next[k][j] = byte_mod(digit[8*j +: 8], WB, P);
        end

        // Stage 2: r * 2^DIGIT_BITS + digit, mod p
        assign dm = mod_add(mod_add(part_reg[k][0], part_reg[k][1], P),
                            mod_add(part_reg[k][2], part_reg[k][3], P), P);
        assign rr = byte_mod({1'b0, res_reg[k]}, WR, P);
        assign res_upd[k] = mod_add(rr, dm, P);
        assign hit[k]     = (res_upd[k] == '0);
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (item_ready)
        begin
            part_reg    <= part_next;
            s1_last_reg <= last;
        end
    end

    // Residue state, digit count, result next values
    always_comb
    begin
        count_inc      = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
        low_hit        = |hit[NUM_LOW_PRIMES-1:0];
        high_hit       = |hit[NUM_PRIMES-1:NUM_LOW_PRIMES];
        divisible_next = low_hit || ((count_inc > threshold_reg) && high_hit);
        s1_valid_next  = item_ready ? item_valid : s1_valid_reg;
        res_next       = res_reg;
        count_next     = count_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (s1_go)
        begin
            if (s1_last_reg)
            begin
                for (int k = 0; k < NUM_PRIMES; k++)
                begin
                    res_next[k] = '0;
                end
                count_next        = '0;
                result_valid_next = 1'b1;
            end
            else
            begin
                res_next   = res_upd;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            count_reg        <= '0;
            for (int k = 0; k < NUM_PRIMES; k++)
            begin
                res_reg[k] <= '0;
            end
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            count_reg        <= count_next;
            res_reg          <= res_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            divisible_reg <= divisible_next;
        end
    end

endmodule

@@ rtl/core/spdc_checker.sv @@
// Port-level checker for the small prime divisibility checker, with its bind.
// Depends on small_prime_divisibility_check_defines.svh.
`include "small_prime_divisibility_check_defines.svh"

module spdc_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pready,
    input  logic                item_valid,
    input  logic                item_ready,
    input  logic                last,
    input  logic                result_valid,
    input  logic                result_ready,
    input  logic                divisible
);

    // Config port never waits
    `SPDC_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

    // Result beat holds until taken
    `SPDC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result beat dropped before accept")
    `SPDC_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(divisible), "result payload changed while stalled")

    // A fresh result follows a last-digit beat through stage 1 and the result register
    `SPDC_ASSERT_NOW(a_result_origin, $rose(result_valid), $past(item_valid && item_ready && last, 2), "result without a last digit")

    // Digit input stalls only behind a waiting result
    `SPDC_ASSERT_NOW(a_stall_cause, !item_ready, result_valid, "digit input stalled with no pending result")

endmodule

bind small_prime_divisibility_check spdc_checker u_spdc_checker (.*);

@@ bench/small_prime_divisibility_check_tb.sv @@
// Testbench for small_prime_divisibility_check: streams numbers digit by digit and
// checks each divisible flag against a residue-tracking predictor. Depends on spdc_pkg.
module small_prime_divisibility_check_tb;
    import spdc_pkg::*;

    localparam logic [ADDR_W-1:0] THRESH_ADDR = {REG_EXT_THRESHOLD, 2'b00};
    localparam logic [ADDR_W-1:0] SPARE_ADDR  = 3'b100;
    localparam int unsigned PRIME_LIST [NUM_PRIMES] = '{
        7, 11, 13, 17, 19, 23, 29, 31,
        37, 41, 43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97
    };
    localparam int SETTLE_CYCLES = 6;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                item_valid = 1'b0;
    logic                item_ready;
    logic [DIGIT_W-1:0]  digit = '0;
    logic                last = 1'b0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic                divisible;

    // predictor state
    int unsigned         mod_residues [NUM_PRIMES];
    int unsigned         radix_residue [NUM_PRIMES];
    logic [COUNT_W-1:0]  digit_tally;
    logic [7:0]          threshold_shadow;
    logic                expected_flags [$];

    int                  fail_count = 0;
    int                  digits_sent = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;

    small_prime_divisibility_check uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .digit        (digit),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .divisible    (divisible)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] mismatch: %s expected %0d got %0d", $time, what, want, got);
        fail_count++;
    endtask

    // result beat checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_flags.size() == 0)
            begin
                report_mismatch("unexpected result beat, divisible", -1, divisible);
            end
            else
            begin
                logic want;
                want = expected_flags.pop_front();
                if (divisible !== want)
                begin
                    report_mismatch("divisible", want, divisible);
                end
            end
        end
    end

    // clear the per-number state
    function automatic void clear_number();
        for (int k = 0; k < NUM_PRIMES; k++)
        begin
            mod_residues[k] = 0;
        end
        digit_tally = '0;
    endfunction

    // fold one digit into every residue; on the last digit queue the flag
    function automatic void absorb_digit(input logic [DIGIT_W-1:0] d, input logic lst);
        logic low_hit;
        logic high_hit;
        low_hit = 1'b0;
        high_hit = 1'b0;
        for (int k = 0; k < NUM_PRIMES; k++)
        begin
            mod_residues[k] = (mod_residues[k] * radix_residue[k] + d % PRIME_LIST[k])
                              % PRIME_LIST[k];
        end
        if (digit_tally != COUNT_MAX)
        begin
            digit_tally = digit_tally + 1'b1;
        end
        if (lst)
        begin
            for (int k = 0; k < NUM_PRIMES; k++)
            begin
                if (mod_residues[k] == 0)
                begin
                    if (k < NUM_LOW_PRIMES)
                        low_hit = 1'b1;
                    else
                        high_hit = 1'b1;
                end
            end
            expected_flags.push_back(low_hit || (digit_tally > threshold_shadow && high_hit));
            clear_number();
        end
    endfunction

    // final digit that makes the number a multiple of the chosen prime
    function automatic logic [DIGIT_W-1:0] aimed_digit(input int k);
        longint unsigned p;
        longint unsigned head;
        longint unsigned span;
        p = PRIME_LIST[k];
        head = (p - (mod_residues[k] * radix_residue[k]) % p) % p;
        span = (64'hFFFF_FFFF - head) / p;
        return DIGIT_W'(head + p * $urandom_range(0, int'(span)));
    endfunction

    function automatic logic [DIGIT_W-1:0] random_digit();
        case ($urandom_range(0, 9))
            6: return '0;
            7: return '1;
            8: return DIGIT_W'($urandom_range(0, 200));
            9: return DIGIT_W'(1) << $urandom_range(0, DIGIT_W - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_prime();
        if ($urandom_range(0, 99) < 70)
            return $urandom_range(NUM_LOW_PRIMES, NUM_PRIMES - 1);
        return $urandom_range(0, NUM_LOW_PRIMES - 1);
    endfunction

    // one digit beat, with random sender gaps ahead of it
    task automatic send_digit(input logic [DIGIT_W-1:0] d, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        digit      <= d;
        last       <= lst;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        absorb_digit(d, lst);
        digits_sent++;
    endtask

    task automatic send_number(input int len, input logic aim);
        for (int i = 0; i < len; i++)
        begin
            if (i == len - 1 && aim)
                send_digit(aimed_digit(pick_prime()), 1'b1);
            else
                send_digit(random_digit(), i == len - 1);
        end
    endtask

    // hold off the sender until every pending flag has arrived
    task automatic wait_results_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_flags.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (addr[ADDR_W-1:2] == REG_EXT_THRESHOLD)
        begin
            threshold_shadow = data[7:0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_threshold_readback();
        logic [DATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THRESH_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        got = prdata;
        if (got !== DATA_W'(threshold_shadow))
        begin
            report_mismatch("threshold readback", threshold_shadow, got);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_threshold(input logic [7:0] value);
        wait_results_drained();
        write_reg(THRESH_ADDR, {{(DATA_W - 8){1'b0}}, value});
        check_threshold_readback();
    endtask

    // field extremes, zero number, single primes, multi-digit at reset threshold
    task automatic test_directed_numbers();
        send_digit('0, 1'b1);
        send_digit(DIGIT_W'(7), 1'b1);
        send_digit(DIGIT_W'(1), 1'b1);
        send_digit('1, 1'b1);
        send_digit(DIGIT_W'(37), 1'b1);
        send_digit('1, 1'b0);
        send_digit('1, 1'b1);
        send_digit('0, 1'b0);
        send_digit('0, 1'b0);
        send_digit('0, 1'b1);
        send_digit(DIGIT_W'(1), 1'b0);
        send_digit(DIGIT_W'(97), 1'b1);
    endtask

    // threshold at its extremes, the count boundary, and a write to a spare address
    task automatic test_threshold_settings();
        set_threshold(8'd0);
        send_digit(DIGIT_W'(37), 1'b1);
        send_digit(DIGIT_W'(97), 1'b1);
        send_digit(aimed_digit(NUM_PRIMES - 2), 1'b1);
        set_threshold(8'd3);
        send_number(3, 1'b1);
        send_number(4, 1'b1);
        set_threshold(8'd255);
        send_digit(DIGIT_W'(37), 1'b1);
        wait_results_drained();
        write_reg(SPARE_ADDR, '0);
        check_threshold_readback();
        send_digit(DIGIT_W'(41), 1'b1);
    endtask

    // digit count runs past 255 and must stick there
    task automatic test_count_saturation();
        set_threshold(8'd254);
        send_number(258, 1'b1);
        send_number(255, 1'b1);
        set_threshold(8'd255);
        send_number(258, 1'b1);
    endtask

    // random numbers under one idling pattern and one threshold
    task automatic test_random_phase(input int snd_pct, input int rcv_pct,
                                     input logic [7:0] thr, input int n_digits);
        int stop_at;
        int r;
        int len;
        set_threshold(thr);
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        stop_at = digits_sent + n_digits;
        while (digits_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                len = $urandom_range(1, 4);
            else if (r < 90)
                len = $urandom_range(5, 12);
            else
                len = $urandom_range(20, 45);
            send_number(len, $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 99) < 3)
            begin
                wait_results_drained();
            end
        end
    endtask

    initial
    begin
        for (int k = 0; k < NUM_PRIMES; k++)
        begin
            radix_residue[k] = 1;
            for (int i = 0; i < DIGIT_BITS; i++)
            begin
                radix_residue[k] = (radix_residue[k] * 2) % PRIME_LIST[k];
            end
        end
        clear_number();
        threshold_shadow = THRESHOLD_RESET;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_numbers();
        test_threshold_settings();
        test_count_saturation();
        test_random_phase(0, 0, 8'd32, 260);
        test_random_phase(47, 0, 8'd0, 260);
        test_random_phase(0, 47, 8'($urandom_range(1, 254)), 260);
        test_random_phase(15, 15, 8'd6, 260);

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_flags.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
